FILE: hw/rtl/drs_pkg.sv
// Package for the descending record sorter.
// Holds the transfer payload structs and the controller state encoding.
// No dependencies.
`default_nettype none

package drs_pkg;

    typedef struct packed {
        logic [15:0] score;
        logic        last_in;
    } drs_in_t;

    typedef struct packed {
        logic [15:0] sorted_score;
        logic [5:0]  entry_number;
        logic        last_out;
        logic        overflow;
    } drs_out_t;

    typedef enum logic [2:0] {
        S_LOAD,
        S_PASS_START,
        S_PASS_FIRST,
        S_PASS_STEP,
        S_PASS_END,
        S_OUT_RD,
        S_OUT_CAP,
        S_OUT_WAIT
    } drs_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/descending_record_sorter.sv
// Descending record sorter: one record memory with a registered read port and a sort controller.
// Records are accepted in the load state whenever s_valid is high; for len >= 2 the sort runs
// bubble passes, one compare-and-write per cycle through the single memory read port; each
// result is read, captured and then held until m_ready. One set at a time: records are not
// accepted while the set is sorted or emitted. Synchronous active-low reset clears the
// controller, fill count and overflow flag; the record memory is not cleared. Uses drs_pkg.
`default_nettype none

module descending_record_sorter #(
    parameter int MAX_ITEMS = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire drs_pkg::drs_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output drs_pkg::drs_out_t      m_data
);
    import drs_pkg::*;

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);

    typedef struct packed {
        logic [15:0]   key;
        logic [AW-1:0] tag;
    } drs_rec_t;

    drs_rec_t   mem [MAX_ITEMS];
    drs_rec_t   rd_data_reg;
    drs_rec_t   carry_reg, carry_next;
    drs_rec_t   wr_data;
    logic       wr_en;
    logic [AW-1:0] wr_addr, rd_addr;

    drs_state_t state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] len_reg, len_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          dropped_reg, dropped_next;
    drs_out_t      out_reg, out_next;

    logic          in_xfer;
    logic          has_room;
    logic [CW-1:0] fill_inc;
    logic          swap;
    logic          step_done;
    logic          out_done;
    logic [5:0]    entry_num;

    assign in_xfer   = s_valid && s_ready;
    assign has_room  = fill_reg < CW'(MAX_ITEMS);
    assign fill_inc  = has_room ? fill_reg + 1'b1 : fill_reg;
    assign swap      = carry_reg.key < rd_data_reg.key;
    assign step_done = CW'(idx_reg) == len_reg - 1'b1;
    assign out_done  = CW'(idx_reg) == fill_reg - 1'b1;
    assign entry_num = 6'(rd_data_reg.tag) + 6'd1;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            fill_reg    <= '0;
            dropped_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            dropped_reg <= dropped_next;
        end
        len_reg   <= len_next;
        idx_reg   <= idx_next;
        carry_reg <= carry_next;
        out_reg   <= out_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD: begin
                if (in_xfer && s_data.last_in) begin
                    state_next = (fill_inc < CW'(2)) ? S_OUT_RD : S_PASS_START;
                end
            end
            S_PASS_START: state_next = S_PASS_FIRST;
            S_PASS_FIRST: state_next = S_PASS_STEP;
            S_PASS_STEP: begin
                if (step_done) begin
                    state_next = S_PASS_END;
                end
            end
            S_PASS_END: state_next = (len_reg <= CW'(2)) ? S_OUT_RD : S_PASS_START;
            S_OUT_RD:   state_next = S_OUT_CAP;
            S_OUT_CAP:  state_next = S_OUT_WAIT;
            S_OUT_WAIT: begin
                if (m_ready) begin
                    state_next = out_done ? S_LOAD : S_OUT_RD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_comb begin
        s_ready      = state_reg == S_LOAD;
        m_valid      = state_reg == S_OUT_WAIT;
        m_data       = out_reg;
        fill_next    = fill_reg;
        dropped_next = dropped_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        carry_next   = carry_reg;
        out_next     = out_reg;
        wr_en        = 1'b0;
        wr_addr      = fill_reg[AW-1:0];
        wr_data      = '{key: s_data.score, tag: fill_reg[AW-1:0]};
        rd_addr      = idx_reg;
        unique case (state_reg)
            S_LOAD: begin
                idx_next = '0;
                if (in_xfer) begin
                    wr_en        = has_room;
                    fill_next    = fill_inc;
                    dropped_next = dropped_reg || !has_room;
                    len_next     = fill_inc;
                end
            end
            S_PASS_START: begin
                rd_addr  = '0;
                idx_next = AW'(1);
            end
            S_PASS_FIRST: begin
                carry_next = rd_data_reg;
                rd_addr    = idx_reg;
            end
            S_PASS_STEP: begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg - 1'b1;
                wr_data    = swap ? rd_data_reg : carry_reg;
                carry_next = swap ? carry_reg : rd_data_reg;
                rd_addr    = idx_reg + 1'b1;
                if (!step_done) begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_PASS_END: begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg;
                wr_data  = carry_reg;
                len_next = len_reg - 1'b1;
                idx_next = '0;
            end
            S_OUT_RD: begin
                rd_addr = idx_reg;
            end
            S_OUT_CAP: begin
                out_next.sorted_score = rd_data_reg.key;
                out_next.entry_number = entry_num;
                out_next.last_out     = out_done;
                out_next.overflow     = dropped_reg;
            end
            S_OUT_WAIT: begin
                if (m_ready) begin
                    if (out_done) begin
                        fill_next    = '0;
                        dropped_next = 1'b0;
                        idx_next     = '0;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire
